// File: src/slc_pkg.sv
// shared types and constants for the scaled linear convolution block
`default_nettype none

package slc_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int TS_W      = 16;
    localparam int FRAC_W    = 16;
    localparam int VALUE_W   = 32;
    localparam int INDEX_W   = 6;
    // counts cover the largest supported length limit (32)
    localparam int CNT_W     = 6;
    // number of buffer banks, also the number of runs that may be outstanding
    localparam int RUN_SLOTS = 2;

    localparam logic [TS_W-1:0] TS_RESET = 16'hFFFF;

    typedef logic [CNT_W-1:0] count_t;

    typedef struct packed {
        logic   bank;
        count_t len1;
        count_t len2;
        logic   overflow;
    } run_desc_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_START,
        BK_ISSUE,
        BK_DRAIN,
        BK_MAG,
        BK_MUL,
        BK_RND,
        BK_OUT
    } back_state_t;

endpackage

`default_nettype wire

// File: src/slc_if.sv
// valid/ready channel interfaces for input and result words
`default_nettype none

interface slc_in_if;
    logic                              valid;
    logic                              ready;
    logic                              seq_select;
    logic signed [slc_pkg::SAMPLE_W-1:0] sample;
    logic                              seq_last;

    modport source (output valid, seq_select, sample, seq_last, input ready);
    modport sink (input valid, seq_select, sample, seq_last, output ready);
endinterface

interface slc_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [slc_pkg::VALUE_W-1:0]  conv_value;
    logic [slc_pkg::INDEX_W-1:0]         out_index;
    logic                                out_last;
    logic                                overflow;

    modport source (output valid, conv_value, out_index, out_last, overflow, input ready);
    modport sink (input valid, conv_value, out_index, out_last, overflow, output ready);
endinterface

`default_nettype wire

// File: src/slc_ram.sv
// generic single write port ram with registered read
`default_nettype none

module slc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: src/slc_front.sv
// loader: accepts words, fills the free buffer bank and posts finished runs
`default_nettype none

module slc_front #(
    parameter int MAX_LEN = 32,
    parameter int IDX_W   = 5
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    slc_in_if.sink                        in_ch,
    output logic                          wr_en1,
    output logic                          wr_en2,
    output logic [IDX_W:0]                wr_addr,
    output logic [slc_pkg::SAMPLE_W-1:0]  wr_data,
    output logic                          push,
    output slc_pkg::run_desc_t            push_desc,
    input  wire logic                     run_done
);

    localparam slc_pkg::count_t CNT_MAX    = slc_pkg::CNT_W'(MAX_LEN);
    localparam logic [1:0]      CREDIT_MAX = 2'(slc_pkg::RUN_SLOTS);

    logic            bank_reg, bank_next;
    slc_pkg::count_t cnt1_reg, cnt1_next;
    slc_pkg::count_t cnt2_reg, cnt2_next;
    logic            done1_reg, done1_next;
    logic            done2_reg, done2_next;
    logic            ovf_reg, ovf_next;
    logic [1:0]      credits_reg, credits_next;

    logic            accept;
    slc_pkg::count_t sel_cnt;
    logic            sel_done;

    assign in_ch.ready = (credits_reg != CREDIT_MAX);
    assign accept      = in_ch.valid && in_ch.ready;
    assign sel_cnt     = in_ch.seq_select ? cnt2_reg : cnt1_reg;
    assign sel_done    = in_ch.seq_select ? done2_reg : done1_reg;
    assign wr_addr     = {bank_reg, sel_cnt[IDX_W-1:0]};
    assign wr_data     = in_ch.sample;

    always_comb
    begin
        bank_next  = bank_reg;
        cnt1_next  = cnt1_reg;
        cnt2_next  = cnt2_reg;
        done1_next = done1_reg;
        done2_next = done2_reg;
        ovf_next   = ovf_reg;
        wr_en1     = 1'b0;
        wr_en2     = 1'b0;
        push       = 1'b0;

        if (accept && !sel_done)
        begin
            if (sel_cnt < CNT_MAX)
            begin
                if (in_ch.seq_select)
                begin
                    wr_en2    = 1'b1;
                    cnt2_next = cnt2_reg + 1'b1;
                end
                else
                begin
                    wr_en1    = 1'b1;
                    cnt1_next = cnt1_reg + 1'b1;
                end
            end
            else
            begin
                // sequence full: word dropped
                ovf_next = 1'b1;
            end
            if (in_ch.seq_last)
            begin
                if (in_ch.seq_select)
                begin
                    done2_next = 1'b1;
                end
                else
                begin
                    done1_next = 1'b1;
                end
            end
        end

        push_desc.bank     = bank_reg;
        push_desc.len1     = cnt1_next;
        push_desc.len2     = cnt2_next;
        push_desc.overflow = ovf_next;

        if (done1_next && done2_next)
        begin
            push       = 1'b1;
            bank_next  = ~bank_reg;
            cnt1_next  = '0;
            cnt2_next  = '0;
            done1_next = 1'b0;
            done2_next = 1'b0;
            ovf_next   = 1'b0;
        end

        case ({push, run_done})
            2'b10:   credits_next = credits_reg + 1'b1;
            2'b01:   credits_next = credits_reg - 1'b1;
            default: credits_next = credits_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg    <= 1'b0;
            cnt1_reg    <= '0;
            cnt2_reg    <= '0;
            done1_reg   <= 1'b0;
            done2_reg   <= 1'b0;
            ovf_reg     <= 1'b0;
            credits_reg <= '0;
        end
        else
        begin
            bank_reg    <= bank_next;
            cnt1_reg    <= cnt1_next;
            cnt2_reg    <= cnt2_next;
            done1_reg   <= done1_next;
            done2_reg   <= done2_next;
            ovf_reg     <= ovf_next;
            credits_reg <= credits_next;
        end
    end

endmodule

`default_nettype wire

// File: src/slc_queue.sv
// two entry queue of run descriptors between loader and engine
`default_nettype none

module slc_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  slc_pkg::run_desc_t      push_desc,
    input  wire logic               pop,
    output slc_pkg::run_desc_t      head,
    output logic                    not_empty,
    output logic                    full
);

    localparam logic [1:0] DEPTH = 2'(slc_pkg::RUN_SLOTS);

    slc_pkg::run_desc_t entry_reg [slc_pkg::RUN_SLOTS];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         level_reg, level_next;
    logic               do_push;
    logic               do_pop;

    assign not_empty = (level_reg != 2'd0);
    assign full      = (level_reg == DEPTH);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        case ({do_push, do_pop})
            2'b10:   level_next = level_reg + 1'b1;
            2'b01:   level_next = level_reg - 1'b1;
            default: level_next = level_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

`default_nettype wire

// File: src/slc_back.sv
// engine: multiply-accumulate over one bank, then scale, round and saturate
`default_nettype none

module slc_back #(
    parameter int MAX_LEN = 32,
    parameter int IDX_W   = 5
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [slc_pkg::TS_W-1:0] bin_width,
    input  wire logic                     q_valid,
    input  slc_pkg::run_desc_t            q_head,
    output logic                          pop,
    output logic                          rd_en,
    output logic [IDX_W:0]                rd_addr1,
    output logic [IDX_W:0]                rd_addr2,
    input  wire logic [slc_pkg::SAMPLE_W-1:0] rd_data1,
    input  wire logic [slc_pkg::SAMPLE_W-1:0] rd_data2,
    slc_out_if.source                     out_ch,
    output logic                          run_done
);

    localparam int PROD_W = 2 * slc_pkg::SAMPLE_W;
    localparam int ACC_W  = PROD_W + $clog2(MAX_LEN) + 1;
    localparam int P_W    = ACC_W + 1;
    localparam int Q_W    = ACC_W + 2 - slc_pkg::FRAC_W;
    localparam int KS_W   = slc_pkg::INDEX_W + 1;

    localparam logic [ACC_W+1:0] ROUND_HALF = (ACC_W+2)'(32'h8000);
    localparam logic [Q_W-1:0]   POS_LIM    = Q_W'(64'h7FFF_FFFF);
    localparam logic [Q_W-1:0]   NEG_LIM    = Q_W'(64'h8000_0000);
    localparam logic [slc_pkg::VALUE_W-1:0] NEG_SAT = 32'h8000_0000;

    slc_pkg::back_state_t state_reg, state_next;
    slc_pkg::run_desc_t   desc_reg, desc_next;
    logic [slc_pkg::INDEX_W-1:0] k_reg, k_next;
    logic [slc_pkg::INDEX_W-1:0] i_reg, i_next;
    logic [slc_pkg::INDEX_W-1:0] ihi_reg, ihi_next;
    logic                 rd_v_reg;
    logic                 prod_v_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                 neg_reg;
    logic [ACC_W-1:0]     mag_reg;
    logic [P_W-1:0]       p_reg;
    logic [slc_pkg::VALUE_W-1:0] value_reg, value_next;

    logic [slc_pkg::INDEX_W-1:0] j_idx;
    logic [slc_pkg::INDEX_W-1:0] i_lo;
    logic [slc_pkg::INDEX_W-1:0] i_hi;
    logic                 last_k;
    logic                 out_take;
    logic [ACC_W-1:0]     hi_prod;
    logic [31:0]          lo_prod;
    logic [ACC_W+1:0]     p_rnd;
    logic [Q_W-1:0]       q;

    assign j_idx    = k_reg - i_reg;
    assign rd_addr1 = {desc_reg.bank, i_reg[IDX_W-1:0]};
    assign rd_addr2 = {desc_reg.bank, j_idx[IDX_W-1:0]};
    // last position is len1 + len2 - 2
    assign last_k   = (KS_W'(k_reg) + KS_W'(2)) == (KS_W'(desc_reg.len1) + KS_W'(desc_reg.len2));

    // first and last terms that touch position k
    assign i_lo = (k_reg >= desc_reg.len2) ? (k_reg - desc_reg.len2 + 1'b1) : '0;
    assign i_hi = (k_reg < desc_reg.len1) ? k_reg : (desc_reg.len1 - 1'b1);

    assign hi_prod = mag_reg[ACC_W-1:slc_pkg::FRAC_W] * bin_width;
    assign lo_prod = mag_reg[slc_pkg::FRAC_W-1:0] * bin_width;
    assign p_rnd   = {1'b0, p_reg} + ROUND_HALF;
    assign q       = p_rnd[ACC_W+1:slc_pkg::FRAC_W];

    assign out_ch.valid      = (state_reg == slc_pkg::BK_OUT);
    assign out_ch.conv_value = value_reg;
    assign out_ch.out_index  = k_reg;
    assign out_ch.out_last   = last_k;
    assign out_ch.overflow   = desc_reg.overflow;
    assign out_take          = out_ch.valid && out_ch.ready;
    assign run_done          = out_take && last_k;

    always_comb
    begin
        state_next = state_reg;
        desc_next  = desc_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        ihi_next   = ihi_reg;
        pop        = 1'b0;
        rd_en      = 1'b0;

        case (state_reg)
            slc_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    pop        = 1'b1;
                    desc_next  = q_head;
                    k_next     = '0;
                    state_next = slc_pkg::BK_START;
                end
            end
            slc_pkg::BK_START:
            begin
                i_next     = i_lo;
                ihi_next   = i_hi;
                state_next = slc_pkg::BK_ISSUE;
            end
            slc_pkg::BK_ISSUE:
            begin
                rd_en = 1'b1;
                if (i_reg == ihi_reg)
                begin
                    state_next = slc_pkg::BK_DRAIN;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            slc_pkg::BK_DRAIN:
            begin
                if (!rd_v_reg && !prod_v_reg)
                begin
                    state_next = slc_pkg::BK_MAG;
                end
            end
            slc_pkg::BK_MAG:
            begin
                state_next = slc_pkg::BK_MUL;
            end
            slc_pkg::BK_MUL:
            begin
                state_next = slc_pkg::BK_RND;
            end
            slc_pkg::BK_RND:
            begin
                state_next = slc_pkg::BK_OUT;
            end
            slc_pkg::BK_OUT:
            begin
                if (out_take)
                begin
                    if (last_k)
                    begin
                        state_next = slc_pkg::BK_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = slc_pkg::BK_START;
                    end
                end
            end
            default:
            begin
                state_next = slc_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (state_reg == slc_pkg::BK_START)
        begin
            acc_next = '0;
        end
        else if (prod_v_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
        else
        begin
            acc_next = acc_reg;
        end

        // round half away from zero on the magnitude, then clamp
        if (!neg_reg)
        begin
            value_next = (q > POS_LIM) ? POS_LIM[slc_pkg::VALUE_W-1:0]
                                       : q[slc_pkg::VALUE_W-1:0];
        end
        else
        begin
            value_next = (q > NEG_LIM) ? NEG_SAT
                                       : (slc_pkg::VALUE_W'(0) - q[slc_pkg::VALUE_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= slc_pkg::BK_IDLE;
            rd_v_reg   <= 1'b0;
            prod_v_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_v_reg   <= rd_en;
            prod_v_reg <= rd_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
        k_reg    <= k_next;
        i_reg    <= i_next;
        ihi_reg  <= ihi_next;
        prod_reg <= $signed(rd_data1) * $signed(rd_data2);
        acc_reg  <= acc_next;
        if (state_reg == slc_pkg::BK_MAG)
        begin
            neg_reg <= acc_reg[ACC_W-1];
            mag_reg <= acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        end
        if (state_reg == slc_pkg::BK_MUL)
        begin
            p_reg <= {1'b0, hi_prod} + P_W'(lo_prod[31:slc_pkg::FRAC_W]);
        end
        if (state_reg == slc_pkg::BK_RND)
        begin
            value_reg <= value_next;
        end
    end

endmodule

`default_nettype wire

// File: src/scaled_linear_convolution.sv
// top level of the scaled linear convolution block
`default_nettype none

// Two sequences of signed Q8.16 samples are loaded one word per cycle; when the
// last word of both has arrived, the block returns len1+len2-1 result words, each
// the full sum of products times the time step register (unsigned Q0.16), rounded
// half away from zero and saturated to signed Q16.16. Samples go into two-bank
// buffers, so the next pair of sequences can load while the engine still works on
// the previous run; input stalls only when both banks hold unfinished runs. The
// engine does one multiply-accumulate per cycle from its buffer ports while it
// issues the products that fall on result position k; it then drains the read
// pipeline, takes the magnitude, scales, rounds and holds the word until the
// output takes it. Words past MAX_LEN are dropped and flag overflow on that whole run.
module scaled_linear_convolution #(
    parameter int MAX_LEN = 32
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_wr_en,
    input  wire logic [slc_pkg::TS_W-1:0] cfg_wr_data,
    slc_in_if.sink                        in_ch,
    slc_out_if.source                     out_ch
);

    localparam int IDX_W = $clog2(MAX_LEN);
    // each bank spans a power of two so the bank bit can sit on top of the index
    localparam int DEPTH = slc_pkg::RUN_SLOTS * (2 ** IDX_W);

    logic [slc_pkg::TS_W-1:0]     ts_reg;
    logic                         wr_en1;
    logic                         wr_en2;
    logic [IDX_W:0]               wr_addr;
    logic [slc_pkg::SAMPLE_W-1:0] wr_data;
    logic                         q_push;
    slc_pkg::run_desc_t           push_desc;
    logic                         q_pop;
    slc_pkg::run_desc_t           q_head;
    logic                         q_not_empty;
    logic                         q_full;
    logic                         rd_en;
    logic [IDX_W:0]               rd_addr1;
    logic [IDX_W:0]               rd_addr2;
    logic [slc_pkg::SAMPLE_W-1:0] rd_data1;
    logic [slc_pkg::SAMPLE_W-1:0] rd_data2;
    logic                         run_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg <= slc_pkg::TS_RESET;
        end
        else if (cfg_wr_en)
        begin
            ts_reg <= cfg_wr_data;
        end
    end

    slc_front #(
        .MAX_LEN (MAX_LEN),
        .IDX_W   (IDX_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .wr_en1    (wr_en1),
        .wr_en2    (wr_en2),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .push      (q_push),
        .push_desc (push_desc),
        .run_done  (run_done)
    );

    slc_ram #(
        .WIDTH (slc_pkg::SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_first_buf (
        .clk     (clk),
        .wr_en   (wr_en1),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr1),
        .rd_data (rd_data1)
    );

    slc_ram #(
        .WIDTH (slc_pkg::SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_second_buf (
        .clk     (clk),
        .wr_en   (wr_en2),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr2),
        .rd_data (rd_data2)
    );

    slc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (push_desc),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    slc_back #(
        .MAX_LEN (MAX_LEN),
        .IDX_W   (IDX_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .bin_width (ts_reg),
        .q_valid   (q_not_empty),
        .q_head    (q_head),
        .pop       (q_pop),
        .rd_en     (rd_en),
        .rd_addr1  (rd_addr1),
        .rd_addr2  (rd_addr2),
        .rd_data1  (rd_data1),
        .rd_data2  (rd_data2),
        .out_ch    (out_ch),
        .run_done  (run_done)
    );

`ifndef SYNTH
    // a run is only posted when a bank is free
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("run posted into a full queue");

    // both banks busy means input must stall
    a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !in_ch.ready)
        else $error("input taken while both banks are busy");

    a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (push_desc.len1 != '0 && push_desc.len2 != '0))
        else $error("run posted with an empty sequence");

    a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        run_done |-> (out_ch.valid && out_ch.ready && out_ch.out_last))
        else $error("run released without its last word");
`endif

endmodule

`default_nettype wire
